// File: rtl/serr_pkg.sv
// ----------------------------------------------------------------------------
// serr_pkg
// shared types and constants for the syscall errno rule table
// ----------------------------------------------------------------------------
package serr_pkg;

  localparam int unsigned RULE_SLOTS_DEF = 32;
  localparam int unsigned NR_W           = 32;
  localparam int unsigned ERRNO_W        = 12;
  localparam int unsigned ENTRY_W        = NR_W + ERRNO_W;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_CLEAR = 2'd2
  } serr_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } serr_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_FIN  = 2'd2
  } serr_state_t;

endpackage

// File: rtl/serr_ram.sv
// ----------------------------------------------------------------------------
// serr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module serr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/syscall_errno_rule_table_unit.sv
// ----------------------------------------------------------------------------
// syscall_errno_rule_table_unit
// rule table mapping syscall numbers to errno values, one slot scanned a cycle
// ----------------------------------------------------------------------------
// Every word in gives exactly one word out. Check and a valid set walk the
// table one slot per cycle through the single read port of the rule ram. A
// walk with no match reads every slot; a match in slot k stops the walk there.
// Clear, set with a negative number or zero errno, and the undefined command
// skip the walk and go straight to the finish state. The input side is ready
// only in the idle state, so it is not ready while a word is being worked on;
// the unit returns to idle as the result is loaded into the output register.
// The result sits in an output register so the next word may be taken while
// it waits; a new result is held back until that register has been taken.
// ----------------------------------------------------------------------------
module syscall_errno_rule_table_unit
  import serr_pkg::*;
#(
  parameter int unsigned RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic [47:0] in_tdata,   // call_num[31:0], errno_value[43:32], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], denied[2], verdict_errno[14:3], zero pad
);

  localparam int unsigned IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(RULE_SLOTS + 1);

  serr_state_t            state_r, state_nxt;
  serr_cmd_t              cmd_r, cmd_nxt;
  logic [NR_W-1:0]        nr_r, nr_nxt;
  logic [ERRNO_W-1:0]     err_r, err_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   cmp_go_r, cmp_go_nxt;
  logic [IW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   hit_r, hit_nxt;
  logic [IW-1:0]          hit_idx_r, hit_idx_nxt;
  logic [ERRNO_W-1:0]     hit_err_r, hit_err_nxt;
  logic                   free_r, free_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic [RULE_SLOTS-1:0]  valid_r, valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  serr_status_t           out_status_r, out_status_nxt;
  logic                   out_denied_r, out_denied_nxt;
  logic [ERRNO_W-1:0]     out_errno_r, out_errno_nxt;

  logic                   in_fire;
  logic                   in_set_ok;
  logic                   set_ok;
  logic                   issue;
  logic [IW-1:0]          rd_idx;
  logic                   hit_now;
  logic                   scan_done;
  logic                   out_free;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  serr_cmd_t              in_cmd;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_cmd     = serr_cmd_t'(in_tuser[1:0]);
  assign in_set_ok  = !in_tdata[NR_W-1] && (in_tdata[NR_W +: ERRNO_W] != '0);
  assign set_ok     = !nr_r[NR_W-1] && (err_r != '0);
  assign issue      = (state_r == ST_SCAN) && (cnt_r < CW'(RULE_SLOTS));
  assign rd_idx     = cnt_r[IW-1:0];
  assign hit_now    = cmp_go_r && !hit_r && valid_r[cmp_idx_r]
                      && (ram_rdata[ENTRY_W-1:ERRNO_W] == nr_r);
  assign scan_done  = hit_now || (!issue && !cmp_go_r);
  assign out_free   = !out_valid_r || out_tready;

  serr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RULE_SLOTS)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_CHECK || (in_cmd == CMD_SET && in_set_ok)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt        = cmd_r;
    nr_nxt         = nr_r;
    err_nxt        = err_r;
    cnt_nxt        = cnt_r;
    cmp_go_nxt     = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_err_nxt    = hit_err_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_denied_nxt = out_denied_r;
    out_errno_nxt  = out_errno_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_r ? hit_idx_r : free_idx_r;
    ram_wdata      = {nr_r, err_r};
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_cmd;
          nr_nxt   = in_tdata[NR_W-1:0];
          err_nxt  = in_tdata[NR_W +: ERRNO_W];
          cnt_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_nxt     = cnt_r + CW'(1);
          cmp_go_nxt  = 1'b1;
          cmp_idx_nxt = rd_idx;
          if (!free_r && !valid_r[rd_idx]) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx;
          end
        end
        if (hit_now) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_err_nxt = ram_rdata[ERRNO_W-1:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_denied_nxt = 1'b0;
          out_errno_nxt  = '0;
          case (cmd_r)
            CMD_SET: begin
              if (!set_ok) begin
                out_status_nxt = STAT_INVALID;
              end else if (hit_r || free_r) begin
                ram_we = 1'b1;
                if (!hit_r) begin
                  valid_nxt[free_idx_r] = 1'b1;
                end
              end else begin
                out_status_nxt = STAT_FULL;
              end
            end
            CMD_CHECK: begin
              out_denied_nxt = hit_r;
              out_errno_nxt  = hit_r ? hit_err_r : '0;
            end
            CMD_CLEAR: begin
              valid_nxt = '0;
            end
            default: begin
              out_status_nxt = STAT_INVALID;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_go_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_go_r    <= cmp_go_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    nr_r         <= nr_nxt;
    err_r        <= err_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_err_r    <= hit_err_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_denied_r <= out_denied_nxt;
    out_errno_r  <= out_errno_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_errno_r, out_denied_r, out_status_r};

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the syscall errno rule table
// ----------------------------------------------------------------------------
// A short directed pass covers the field extremes, rule update, rejected sets,
// the undefined command, negative lookups and clear. A random pass follows:
// table fill bursts that run into the full case, then mixed sets, checks, clears
// and undefined words, partly on recent numbers. Each accepted word is run through
// a scoreboard that keeps its own copy of the table and queues the verdict.
// Each result word is compared field by field with the oldest queued verdict.
// The sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
  import serr_pkg::*;

  localparam int unsigned SLOTS = RULE_SLOTS_DEF;
  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam int unsigned WORD_TARGET = 900;

  class errno_rule_checker;
    typedef struct packed {
      logic [1:0]  status;
      logic        denied;
      logic [11:0] errno_v;
    } verdict_t;

    bit          rule_live[SLOTS];
    logic [31:0] rule_nr[SLOTS];
    logic [11:0] rule_errno[SLOTS];
    verdict_t    pending_verdicts[$];
    int          errors;
    int          n_words;
    int          n_stored;
    int          n_denied;
    int          n_full;
    int          n_rejected;
    int          n_clear;

    function int find_rule(logic [31:0] nr);
      int i;
      for (i = 0; i < SLOTS; i++) begin
        if (rule_live[i] && rule_nr[i] == nr) return i;
      end
      return SLOTS;
    endfunction

    function void note_word(logic [1:0] cmd, logic [31:0] nr, logic [11:0] err);
      verdict_t v;
      int hit;
      int slot;
      int i;
      v = '0;
      hit = find_rule(nr);
      slot = SLOTS;
      n_words++;
      case (cmd)
        CMD_SET: begin
          if (nr[31] || err == 12'd0) begin
            v.status = STAT_INVALID;
            n_rejected++;
          end else if (hit < SLOTS) begin
            rule_errno[hit] = err;
            n_stored++;
          end else begin
            for (i = 0; i < SLOTS; i++) begin
              if (!rule_live[i]) begin
                slot = i;
                break;
              end
            end
            if (slot < SLOTS) begin
              rule_live[slot] = 1'b1;
              rule_nr[slot] = nr;
              rule_errno[slot] = err;
              n_stored++;
            end else begin
              v.status = STAT_FULL;
              n_full++;
            end
          end
        end
        CMD_CHECK: begin
          if (hit < SLOTS) begin
            v.denied = 1'b1;
            v.errno_v = rule_errno[hit];
            n_denied++;
          end
        end
        CMD_CLEAR: begin
          for (i = 0; i < SLOTS; i++) rule_live[i] = 1'b0;
          n_clear++;
        end
        default: begin
          v.status = STAT_INVALID;
          n_rejected++;
        end
      endcase
      pending_verdicts.push_back(v);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_word(logic [15:0] data);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result word 0x%04h with nothing pending", data));
        return;
      end
      v = pending_verdicts.pop_front();
      if (data[1:0] !== v.status)
        report($sformatf("status %0d, predicted %0d", data[1:0], v.status));
      if (data[2] !== v.denied)
        report($sformatf("denied %0b, predicted %0b", data[2], v.denied));
      if (data[14:3] !== v.errno_v)
        report($sformatf("errno %0d, predicted %0d", data[14:3], v.errno_v));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = 2'd0;   // command[1:0]
  logic [47:0] in_tdata = '0;     // call_num[31:0], errno_value[43:32], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // status[1:0], denied[2], verdict_errno[14:3], zero pad

  errno_rule_checker sb = new();
  int          words_sent;
  int          burst_left;
  int          rx_left;
  int          rx_mode;
  logic [31:0] seen_nrs[$];
  logic [31:0] nr_pool[12];

  syscall_errno_rule_table_unit #(
    .RULE_SLOTS(SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      2: out_tready <= ($urandom_range(0, 3) != 0);
      3: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic push_word(input logic [1:0] cmd, input logic [31:0] nr,
                           input logic [11:0] err);
    pace();
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0, err, nr};
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, nr, err);
    words_sent++;
  endtask

  function automatic void remember(logic [31:0] nr);
    seen_nrs.push_back(nr);
    if (seen_nrs.size() > 48) void'(seen_nrs.pop_front());
  endfunction

  function automatic logic [31:0] pick_nr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && seen_nrs.size() != 0) return seen_nrs[$urandom_range(0, seen_nrs.size() - 1)];
    if (r < 75) return nr_pool[$urandom_range(0, 11)];
    if (r < 90) return $urandom & 32'h7fff_ffff;
    return $urandom;
  endfunction

  function automatic logic [11:0] pick_errno();
    if ($urandom_range(0, 19) == 0) return 12'd0;
    return 12'($urandom_range(1, 4095));
  endfunction

  task automatic fill_table();
    logic [31:0] nr;
    repeat (SLOTS + 2) begin
      nr = $urandom & 32'h7fff_ffff;
      push_word(CMD_SET, nr, 12'($urandom_range(1, 4095)));
      remember(nr);
    end
    repeat (4) push_word(CMD_CHECK, pick_nr(), 12'($urandom));
  endtask

  task automatic random_word();
    logic [31:0] nr;
    logic [11:0] err;
    int r;
    r = $urandom_range(0, 199);
    nr = pick_nr();
    if (r < 3) begin
      if ($urandom_range(0, 1) != 0) push_word(CMD_CLEAR, $urandom, 12'($urandom));
      fill_table();
    end else if (r < 10) begin
      push_word(CMD_CLEAR, $urandom, 12'($urandom));
    end else if (r < 14) begin
      push_word(CMD_UNDEF, $urandom, 12'($urandom));
    end else if (r < 100) begin
      err = pick_errno();
      push_word(CMD_SET, nr, err);
      if (!nr[31] && err != 12'd0) remember(nr);
    end else begin
      push_word(CMD_CHECK, nr, 12'($urandom));
    end
  endtask

  initial begin
    int i;
    nr_pool[0] = 32'd0;
    nr_pool[1] = 32'h7fff_ffff;
    nr_pool[2] = 32'h8000_0000;
    nr_pool[3] = 32'hffff_ffff;
    for (i = 4; i < 12; i++) nr_pool[i] = (i < 8) ? $urandom_range(1, 400) : $urandom;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    push_word(CMD_CHECK, 32'd0, 12'd0);
    push_word(CMD_SET, 32'd0, 12'd1);
    push_word(CMD_SET, 32'h7fff_ffff, 12'hfff);
    push_word(CMD_CHECK, 32'd0, 12'hfff);
    push_word(CMD_CHECK, 32'h7fff_ffff, 12'd0);
    push_word(CMD_SET, 32'h8000_0000, 12'd5);
    push_word(CMD_SET, 32'hffff_ffff, 12'd7);
    push_word(CMD_SET, 32'd100, 12'd0);
    push_word(CMD_CHECK, 32'h8000_0000, 12'd0);
    push_word(CMD_CHECK, 32'hffff_ffff, 12'hfff);
    push_word(CMD_SET, 32'd0, 12'haaa);
    push_word(CMD_CHECK, 32'd0, 12'h555);
    push_word(CMD_UNDEF, 32'h5555_5555, 12'h555);
    push_word(CMD_UNDEF, 32'haaaa_aaaa, 12'haaa);
    push_word(CMD_CHECK, 32'd100, 12'd0);
    push_word(CMD_CLEAR, 32'hffff_ffff, 12'hfff);
    push_word(CMD_CHECK, 32'd0, 12'd0);
    push_word(CMD_CHECK, 32'h7fff_ffff, 12'd0);
    push_word(CMD_SET, 32'h7fff_ffff, 12'h800);
    push_word(CMD_SET, 32'd1, 12'd1);
    push_word(CMD_CHECK, 32'h7fff_ffff, 12'd0);
    push_word(CMD_CHECK, 32'd1, 12'd0);
    push_word(CMD_CLEAR, 32'd0, 12'd0);

    fill_table();
    push_word(CMD_SET, 32'h1234_5678, 12'h321);
    while (words_sent < WORD_TARGET) random_word();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d words: %0d rules stored or updated, %0d denied checks",
             sb.n_words, sb.n_stored, sb.n_denied);
    $display("  %0d sets into a full table, %0d rejected words, %0d clears",
             sb.n_full, sb.n_rejected, sb.n_clear);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
